// ===== design/rfs_pkg.sv =====
// Shared types and constants for the redundant fan selector.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rfs_pkg;

  localparam int FAN_COUNT = 4;
  localparam int PTR_W     = $clog2(FAN_COUNT);
  localparam int LEVEL_W   = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 4;

  typedef logic [FAN_COUNT-1:0] fan_mask_t;
  typedef logic [PTR_W-1:0]     fan_ptr_t;
  typedef logic [LEVEL_W-1:0]   level_t;

  // temperature level codes
  localparam level_t LVL_UNKNOWN = 3'd0;
  localparam level_t LVL_BELOW   = 3'd1;
  localparam level_t LVL_ABOVE   = 3'd2;
  localparam level_t LVL_CRIT1   = 3'd3;
  localparam level_t LVL_CRIT2   = 3'd4;
  localparam level_t LVL_CRIT3   = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_ENABLE = 1'd1;

  typedef struct packed {
    logic      temp_mode;
    fan_mask_t unit_enable;
  } rfs_cfg_t;

endpackage

`default_nettype wire

// ===== design/rfs_select.sv =====
// Combinational fan selection for one transfer: primaries, fault replacement,
// critical-level backups and the rotating backup pointer. Uses rfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfs_select (
  input  var rfs_pkg::rfs_cfg_t  cfg,
  input  var rfs_pkg::level_t    temp_level,
  input  var rfs_pkg::fan_mask_t scheduled_mask,
  input  var rfs_pkg::fan_mask_t fault_mask,
  input  var rfs_pkg::fan_mask_t req_cur,
  input  var rfs_pkg::fan_ptr_t  ptr_cur,
  output rfs_pkg::fan_mask_t     req_nxt,
  output rfs_pkg::fan_ptr_t      ptr_nxt
);

  rfs_pkg::fan_mask_t prim;
  rfs_pkg::fan_mask_t spare_ok;
  rfs_pkg::fan_mask_t spare_any;
  rfs_pkg::fan_mask_t req_prim_only;
  rfs_pkg::fan_mask_t req_plus1;
  rfs_pkg::fan_mask_t req_plus2;
  rfs_pkg::fan_ptr_t  ptr_eval;
  rfs_pkg::fan_ptr_t  k;
  rfs_pkg::fan_ptr_t  kp;
  logic               found;
  logic [1:0]         got;

  function automatic rfs_pkg::fan_ptr_t next_idx(input rfs_pkg::fan_ptr_t i);
    if (int'(i) == rfs_pkg::FAN_COUNT - 1) begin
      return '0;
    end
    return i + rfs_pkg::fan_ptr_t'(1);
  endfunction

  assign prim      = scheduled_mask & cfg.unit_enable;
  assign spare_ok  = cfg.unit_enable & ~prim & ~fault_mask;
  assign spare_any = cfg.unit_enable & ~prim;

  // pointer: one past highest primary, held when none
  always_comb begin
    ptr_eval = ptr_cur;
    for (int i = 0; i < rfs_pkg::FAN_COUNT; i++) begin
      if (prim[i]) begin
        ptr_eval = next_idx(rfs_pkg::fan_ptr_t'(i));
      end
    end
  end

  // faulted primaries replaced by first healthy spare, circular from the fan
  always_comb begin
    req_prim_only = prim;
    found = 1'b0;
    k = '0;
    for (int i = 0; i < rfs_pkg::FAN_COUNT; i++) begin
      if (prim[i] && fault_mask[i]) begin
        req_prim_only[i] = 1'b0;
        found = 1'b0;
        k = rfs_pkg::fan_ptr_t'(i);
        for (int j = 0; j < rfs_pkg::FAN_COUNT; j++) begin
          if (!found && spare_ok[k]) begin
            req_prim_only[k] = 1'b1;
            found = 1'b1;
          end
          k = next_idx(k);
        end
      end
    end
  end

  // critical levels: one or two spares from the pointer
  always_comb begin
    req_plus1 = prim;
    req_plus2 = prim;
    got = 2'd0;
    kp = ptr_eval;
    for (int j = 0; j < rfs_pkg::FAN_COUNT; j++) begin
      if (spare_any[kp]) begin
        if (got == 2'd0) begin
          req_plus1[kp] = 1'b1;
          req_plus2[kp] = 1'b1;
          got = 2'd1;
        end else if (got == 2'd1) begin
          req_plus2[kp] = 1'b1;
          got = 2'd2;
        end
      end
      kp = next_idx(kp);
    end
  end

  always_comb begin
    req_nxt = req_cur;
    ptr_nxt = ptr_cur;
    if (!cfg.temp_mode) begin
      req_nxt = req_prim_only;
      ptr_nxt = ptr_eval;
    end else begin
      case (temp_level)
        rfs_pkg::LVL_BELOW: begin
          req_nxt = '0;
        end
        rfs_pkg::LVL_ABOVE: begin
          req_nxt = req_prim_only;
          ptr_nxt = ptr_eval;
        end
        rfs_pkg::LVL_CRIT1: begin
          req_nxt = req_plus1;
          ptr_nxt = ptr_eval;
        end
        rfs_pkg::LVL_CRIT2: begin
          req_nxt = req_plus2;
          ptr_nxt = ptr_eval;
        end
        rfs_pkg::LVL_CRIT3: begin
          req_nxt = cfg.unit_enable;
        end
        default: begin
          // unknown level: hold
          req_nxt = req_cur;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/redundant_fan_selector_top.sv =====
// Top level of the redundant fan selector: handshake, configuration and state
// registers around rfs_select. Uses rfs_pkg and rfs_select.
`timescale 1ns / 1ps
`default_nettype none

// Takes one input transfer per cycle while out_ready is high and returns one
// fan_on_mask per transfer, registered: the result appears the cycle after
// the input is taken. The output register holds the current fan request; a
// new input is taken whenever that register is empty or being taken in the
// same cycle, so the sustained rate is one item per clock. Configuration
// writes apply at once and should only be made while no result is pending.
module redundant_fan_selector_top (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire [rfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [rfs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire [rfs_pkg::LEVEL_W-1:0]         in_temp_level,
  input  wire [rfs_pkg::FAN_COUNT-1:0]       in_scheduled_mask,
  input  wire [rfs_pkg::FAN_COUNT-1:0]       in_fault_mask,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [rfs_pkg::FAN_COUNT-1:0]      out_fan_on_mask
);

  rfs_pkg::rfs_cfg_t  cfg_r;
  rfs_pkg::fan_mask_t req_r;
  rfs_pkg::fan_mask_t req_nxt;
  rfs_pkg::fan_ptr_t  ptr_r;
  rfs_pkg::fan_ptr_t  ptr_nxt;
  logic               out_valid_r;
  logic               in_xfer;

  assign in_ready        = !out_valid_r || out_ready;
  assign in_xfer         = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_fan_on_mask = req_r;

  rfs_select u_select (
    .cfg            (cfg_r),
    .temp_level     (in_temp_level),
    .scheduled_mask (in_scheduled_mask),
    .fault_mask     (in_fault_mask),
    .req_cur        (req_r),
    .ptr_cur        (ptr_r),
    .req_nxt        (req_nxt),
    .ptr_nxt        (ptr_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_mode   <= 1'b0;
      cfg_r.unit_enable <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rfs_pkg::CFG_TEMP_MODE: begin
          cfg_r.temp_mode <= cfg_data[0];
        end
        rfs_pkg::CFG_UNIT_ENABLE: begin
          cfg_r.unit_enable <= cfg_data[rfs_pkg::FAN_COUNT-1:0];
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        req_r       <= req_nxt;
        ptr_r       <= ptr_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_redundant_fan_selector_top.sv =====
// Self-checking testbench for redundant_fan_selector_top: directed and random fan requests
// over valid/ready with random idling, checked against a built-in fan selection predictor.
// Depends on rfs_pkg and redundant_fan_selector_top.
`timescale 1ns / 1ps

module tb_redundant_fan_selector_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 14;
  localparam int PHASE_ITEMS = 50;
  localparam int CFG_DW      = rfs_pkg::CFG_DATA_W;

  typedef struct packed {
    rfs_pkg::level_t    lvl;
    rfs_pkg::fan_mask_t sched;
    rfs_pkg::fan_mask_t fault;
  } fan_cmd_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [rfs_pkg::CFG_IDX_W-1:0]  cfg_index = rfs_pkg::CFG_TEMP_MODE;
  logic [rfs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  rfs_pkg::level_t                in_temp_level = rfs_pkg::LVL_UNKNOWN;
  rfs_pkg::fan_mask_t             in_scheduled_mask = '0;
  rfs_pkg::fan_mask_t             in_fault_mask = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  rfs_pkg::fan_mask_t             out_fan_on_mask;

  fan_cmd_t           cmd_q[$];
  rfs_pkg::fan_mask_t fan_on_q[$];
  int                 errors = 0;
  int                 cycle_count = 0;
  int                 send_gap = 0;
  int                 recv_stall = 0;
  bit                 no_idle = 1'b0;

  logic               mdl_temp_mode = 1'b0;
  rfs_pkg::fan_mask_t mdl_enable = '0;
  rfs_pkg::fan_mask_t mdl_request = '0;
  rfs_pkg::fan_ptr_t  mdl_backup_ptr = '0;

  redundant_fan_selector_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_temp_level     (in_temp_level),
    .in_scheduled_mask (in_scheduled_mask),
    .in_fault_mask     (in_fault_mask),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_fan_on_mask   (out_fan_on_mask)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int next_fan(int i);
    return (i + 1 >= rfs_pkg::FAN_COUNT) ? 0 : i + 1;
  endfunction

  // primaries = scheduled and enabled; pointer moves past the highest one
  function automatic rfs_pkg::fan_mask_t take_primaries(rfs_pkg::fan_mask_t sched);
    rfs_pkg::fan_mask_t p;
    p = sched & mdl_enable;
    for (int i = 0; i < rfs_pkg::FAN_COUNT; i++)
      if (p[i]) mdl_backup_ptr = rfs_pkg::fan_ptr_t'(next_fan(i));
    return p;
  endfunction

  function automatic rfs_pkg::fan_mask_t swap_faulted(rfs_pkg::fan_mask_t sched,
                                                      rfs_pkg::fan_mask_t fault);
    rfs_pkg::fan_mask_t p, req, spare;
    int                 k;
    bit                 found;
    p = take_primaries(sched);
    req = p;
    spare = mdl_enable & ~p & ~fault;
    for (int i = 0; i < rfs_pkg::FAN_COUNT; i++) begin
      if (req[i] && fault[i]) begin
        req[i] = 1'b0;
        k = i;
        found = 1'b0;
        for (int j = 0; j < rfs_pkg::FAN_COUNT; j++) begin
          if (!found && spare[k]) begin
            req[k] = 1'b1;
            found = 1'b1;
          end
          k = next_fan(k);
        end
      end
    end
    return req;
  endfunction

  function automatic rfs_pkg::fan_mask_t add_backups(rfs_pkg::fan_mask_t sched, int extra);
    rfs_pkg::fan_mask_t p, req, spare;
    int                 k, got;
    p = take_primaries(sched);
    req = p;
    spare = mdl_enable & ~p;
    k = int'(mdl_backup_ptr);
    got = 0;
    for (int j = 0; j < rfs_pkg::FAN_COUNT; j++) begin
      if (got < extra && spare[k]) begin
        req[k] = 1'b1;
        got++;
      end
      k = next_fan(k);
    end
    return req;
  endfunction

  function automatic rfs_pkg::fan_mask_t predict_fan_on(fan_cmd_t c);
    if (!mdl_temp_mode) begin
      mdl_request = swap_faulted(c.sched, c.fault);
    end else begin
      case (c.lvl)
        rfs_pkg::LVL_BELOW: mdl_request = '0;
        rfs_pkg::LVL_ABOVE: mdl_request = swap_faulted(c.sched, c.fault);
        rfs_pkg::LVL_CRIT1: mdl_request = add_backups(c.sched, 1);
        rfs_pkg::LVL_CRIT2: mdl_request = add_backups(c.sched, 2);
        rfs_pkg::LVL_CRIT3: mdl_request = mdl_enable;
        default: ;
      endcase
    end
    return mdl_request;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  always @(posedge clk) begin
    fan_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        c.lvl = in_temp_level;
        c.sched = in_scheduled_mask;
        c.fault = in_fault_mask;
        fan_on_q.push_back(predict_fan_on(c));
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          c = cmd_q.pop_front();
          in_valid <= 1'b1;
          in_temp_level <= c.lvl;
          in_scheduled_mask <= c.sched;
          in_fault_mask <= c.fault;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rfs_pkg::fan_mask_t exp_mask;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (fan_on_q.size() == 0) begin
          $error("unexpected transfer: fan_on_mask actual %h", out_fan_on_mask);
          errors++;
        end else begin
          exp_mask = fan_on_q.pop_front();
          if (out_fan_on_mask !== exp_mask) begin
            $error("fan_on_mask mismatch: expected %h actual %h", exp_mask, out_fan_on_mask);
            errors++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic wait_drain();
    do @(negedge clk);
    while (cmd_q.size() != 0 || in_valid || fan_on_q.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_cfg(logic mode, rfs_pkg::fan_mask_t enable);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= rfs_pkg::CFG_TEMP_MODE;
    cfg_data <= CFG_DW'(mode);
    @(posedge clk);
    cfg_index <= rfs_pkg::CFG_UNIT_ENABLE;
    cfg_data <= CFG_DW'(enable);
    @(posedge clk);
    cfg_we <= 1'b0;
    mdl_temp_mode = mode;
    mdl_enable = enable;
  endtask

  task automatic add_cmd(rfs_pkg::level_t lvl, rfs_pkg::fan_mask_t sched,
                         rfs_pkg::fan_mask_t fault);
    fan_cmd_t c;
    c.lvl = lvl;
    c.sched = sched;
    c.fault = fault;
    cmd_q.push_back(c);
  endtask

  initial begin
    logic               mode;
    rfs_pkg::fan_mask_t enable;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fault replacement only; level is ignored with temperature mode off
    write_cfg(1'b0, 4'hF);
    add_cmd(rfs_pkg::LVL_ABOVE, 4'h0, 4'h0);
    add_cmd(rfs_pkg::LVL_ABOVE, 4'hF, 4'h0);
    add_cmd(rfs_pkg::LVL_ABOVE, 4'h3, 4'h1);
    add_cmd(rfs_pkg::LVL_ABOVE, 4'h3, 4'h3);
    add_cmd(rfs_pkg::LVL_ABOVE, 4'hF, 4'hF);
    add_cmd(rfs_pkg::LVL_CRIT3, 4'h8, 4'h4);
    wait_drain();

    // every level code, pointer hold, unknown codes hold the request
    write_cfg(1'b1, 4'b1011);
    add_cmd(rfs_pkg::LVL_CRIT3, 4'h0, 4'h0);
    add_cmd(rfs_pkg::LVL_UNKNOWN, 4'hF, 4'hF);
    add_cmd(rfs_pkg::LVL_BELOW, 4'hF, 4'h0);
    add_cmd(rfs_pkg::LVL_ABOVE, 4'h1, 4'h1);
    add_cmd(rfs_pkg::LVL_CRIT1, 4'h2, 4'h0);
    add_cmd(rfs_pkg::LVL_CRIT2, 4'h1, 4'hF);
    add_cmd(rfs_pkg::LVL_CRIT2, 4'h0, 4'h0);
    add_cmd(rfs_pkg::level_t'(6), 4'h0, 4'h0);
    add_cmd(rfs_pkg::level_t'(7), 4'hF, 4'hF);
    add_cmd(rfs_pkg::LVL_ABOVE, 4'hF, 4'hF);
    wait_drain();

    // no fan enabled
    write_cfg(1'b1, 4'h0);
    add_cmd(rfs_pkg::LVL_CRIT3, 4'hF, 4'h0);
    add_cmd(rfs_pkg::LVL_CRIT2, 4'hF, 4'h0);
    add_cmd(rfs_pkg::LVL_ABOVE, 4'hF, 4'hF);
    wait_drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin mode = 1'b1; enable = 4'hF; end
        1: begin mode = 1'b1; enable = 4'h0; end
        2: begin mode = 1'b0; enable = 4'hF; end
        3: begin mode = 1'b0; enable = 4'h0; end
        default: begin
          mode = ($urandom_range(0, 3) != 0);
          enable = rfs_pkg::fan_mask_t'($urandom_range(0, 15));
        end
      endcase
      write_cfg(mode, enable);
      no_idle = (ph % 5 == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2 && ph % 3 == 0) wait_drain();
        add_cmd(($urandom_range(0, 9) == 0) ? rfs_pkg::level_t'($urandom_range(6, 7))
                                             : rfs_pkg::level_t'($urandom_range(0, 5)),
                rfs_pkg::fan_mask_t'($urandom_range(0, 15)),
                rfs_pkg::fan_mask_t'($urandom_range(0, 15)));
      end
      wait_drain();
    end

    repeat (8) @(posedge clk);
    if (fan_on_q.size() != 0) begin
      $error("%0d fan_on_mask results never arrived", fan_on_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/rfs_pkg.sv
design/rfs_select.sv
design/redundant_fan_selector_top.sv
tb/tb_redundant_fan_selector_top.sv
